// ----- rtl/core/thermdiv_pkg.sv -----
// Shared types, constants and helpers for the thermistor divider to temperature block.
// No dependencies.
package thermdiv_pkg;

   // Resistor fraction bits; the format cancels in the resistance ratio.
   localparam int RES_FRAC_BITS = 12;
   localparam int LOG_FRAC = 24;
   localparam int ABS_ZERO_CENTI = 27315;
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   localparam int NUM_W = 40;            // 16 x 24 product
   localparam int LOG_W = 30;            // integer part 6 bits, fraction 24 bits
   localparam int BNUM_W = 47;           // b * 100 * 2^20
   localparam int DIV_W = BNUM_W;        // quotient width of both dividers
   localparam int DEN_W = 48;            // divisor width of both dividers

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SUPPLY = 3'd0,
      CSR_SERIES = 3'd1,
      CSR_REFRES = 3'd2,
      CSR_REFTMP = 3'd3,
      CSR_BETA   = 3'd4
   } csr_addr_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_HIGH = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] supply_mv;
      logic [23:0] series_resistance;
      logic [23:0] ref_resistance;
      logic signed [7:0] ref_temp_c;
      logic [19:0] beta_value;
   } csr_type;

   // Payload that rides alongside the log and divide pipelines.
   typedef struct packed {
      status_type status;
      logic [BNUM_W-1:0] bnum;
   } side_type;

endpackage

// ----- rtl/core/thermdiv_if.sv -----
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface thermdiv_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/thermdiv_log2.sv -----
// Pipelined log2 of a 40-bit integer in unsigned Q.24, one squaring per stage.
// Depends on thermdiv_pkg.
module thermdiv_log2 import thermdiv_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  value,
   output logic [LOG_W-1:0]  result
);

   logic [31:0]      man_ff   [0:LOG_FRAC];
   logic [LOG_W-1:0] acc_ff   [0:LOG_FRAC];
   logic [5:0]       msb;
   logic [31:0]      man_in;

   always_comb begin
      msb = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (value[i]) msb = 6'(i);
      end
   end

   // Normalise to Q1.31.
   always_comb begin
      logic [NUM_W+31:0] wide;
      wide = {32'd0, value} << 31;
      man_in = 32'(wide >> msb);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         man_ff[0] <= man_in;
         acc_ff[0] <= {msb, {LOG_FRAC{1'b0}}};
      end
   end

   for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] m;
      assign sq = 64'(man_ff[k]) * 64'(man_ff[k]);
      assign m  = 33'(sq >> 31);
      always_ff @(posedge clock) begin
         if (advance) begin
            if (m[32]) begin
               man_ff[k+1] <= m[32:1];
               acc_ff[k+1] <= acc_ff[k] | (LOG_W'(1) << (LOG_FRAC-1-k));
            end else begin
               man_ff[k+1] <= m[31:0];
               acc_ff[k+1] <= acc_ff[k];
            end
         end
      end
   end

   assign result = acc_ff[LOG_FRAC];

endmodule

// ----- rtl/core/thermdiv_div.sv -----
// Pipelined restoring divider with round-half-up, one quotient bit per stage.
// Depends on thermdiv_pkg.
module thermdiv_div import thermdiv_pkg::*; #(
   parameter type tag_type = logic
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [BNUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   input  tag_type           tag_in,
   output logic [DIV_W-1:0]  quotient,
   output tag_type           tag_out
);

   localparam int NW = BNUM_W + 1;

   logic [DIV_W-1:0] num_ff [0:DIV_W];
   logic [DEN_W-1:0] den_ff [0:DIV_W];
   logic [DEN_W:0]   rem_ff [0:DIV_W];
   logic [DIV_W-1:0] quo_ff [0:DIV_W];
   tag_type          tag_ff [0:DIV_W];
   logic [NW-1:0]    sum;

   // Rounding: (n + d/2) / d. The quotient fits DIV_W bits, so the top bit of
   // the rounded dividend is already below the divisor: seed the remainder with it.
   assign sum = NW'(dividend) + NW'(divisor >> 1);

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= sum[DIV_W-1:0];
         den_ff[0] <= divisor;
         rem_ff[0] <= (DEN_W+1)'(sum[NW-1]);
         quo_ff[0] <= '0;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar k = 0; k < DIV_W; k++) begin : g_bit
      logic [DEN_W+1:0] trial;
      logic [DEN_W+1:0] sh;
      assign sh    = {rem_ff[k], num_ff[k][DIV_W-1-k]};
      assign trial = sh - {2'b00, den_ff[k]};
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[k+1] <= num_ff[k];
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
            if (!trial[DEN_W+1]) begin
               rem_ff[k+1] <= trial[DEN_W:0];
               quo_ff[k+1] <= quo_ff[k] | (DIV_W'(1) << (DIV_W-1-k));
            end else begin
               rem_ff[k+1] <= sh[DEN_W:0];
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   assign quotient = quo_ff[DIV_W];
   assign tag_out  = tag_ff[DIV_W];

endmodule

// ----- rtl/core/thermistor_divider_to_temperature.sv -----
// Thermistor divider to temperature converter: takes one divider voltage word
// per cycle and returns one temperature word (hundredths of a degree Celsius)
// with a status code. Fully pipelined: a new word enters every cycle. The
// pipe is made of the input stage, the two 48-stage bit-per-cycle dividers
// (B/Tref, then B/D), the two stages that form D between them and the output
// register; the 25-stage log2 units run beside the first divider. All stages
// advance together, so a waiting output word with rsp not ready holds the
// whole pipe and req.ready.
// Depends on thermdiv_pkg, thermdiv_if, thermdiv_log2 and thermdiv_div.
module thermistor_divider_to_temperature import thermdiv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   thermdiv_if.sink              req,
   thermdiv_if.source            rsp
);

   csr_type csr_ff;

   // Hold configuration; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.supply_mv         <= 16'd5000;
         csr_ff.series_resistance <= 24'd40960;
         csr_ff.ref_resistance    <= 24'd40960;
         csr_ff.ref_temp_c        <= 8'sd25;
         csr_ff.beta_value        <= 20'd54960;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SUPPLY: csr_ff.supply_mv         <= csr_data[15:0];
            CSR_SERIES: csr_ff.series_resistance <= csr_data;
            CSR_REFRES: csr_ff.ref_resistance    <= csr_data;
            CSR_REFTMP: csr_ff.ref_temp_c        <= csr_data[7:0];
            CSR_BETA:   csr_ff.beta_value        <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // Pipeline stalls as one: advance whenever the output slot is free.
   // Valid bits cover stage A, the first divider, the two D stages and the
   // second divider; the output register follows.
   localparam int DEPTH = 1 + (DIV_W + 1) + 2 + (DIV_W + 1);

   logic             advance;
   logic [DEPTH-1:0] vld_ff;
   logic             out_valid_ff;
   logic [15:0]      out_temp_ff;
   status_type       out_status_ff;

   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
      end
   end

   // Stage A: classify the sample and form the two products.
   logic [15:0]  s_in;
   logic [23:0]  rs, rr;
   logic [19:0]  bv;
   assign s_in = req.data;
   assign rs = (csr_ff.series_resistance == '0) ? 24'd1 : csr_ff.series_resistance;
   assign rr = (csr_ff.ref_resistance == '0) ? 24'd1 : csr_ff.ref_resistance;
   assign bv = (csr_ff.beta_value == '0) ? 20'd1 : csr_ff.beta_value;

   logic [NUM_W-1:0] num_ff, den_ff;
   side_type         sa_ff;
   logic [15:0]      tc_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= NUM_W'(s_in) * NUM_W'(rs);
         den_ff <= NUM_W'(csr_ff.supply_mv - s_in) * NUM_W'(rr);
         if (s_in == '0) sa_ff.status <= ST_ZERO;
         else if (s_in >= csr_ff.supply_mv) sa_ff.status <= ST_HIGH;
         else sa_ff.status <= ST_OK;
         sa_ff.bnum <= BNUM_W'(BNUM_W'(bv) * BNUM_W'(100)) << 20;
         tc_ff <= 16'(18'(signed'(csr_ff.ref_temp_c)) * 18'sd100 + 18'sd27315);
      end
   end

   // Stage B: log2 of both products, B/Tref in parallel on a divider.
   logic [LOG_W-1:0] lnum, lden;
   thermdiv_log2 u_log_num (.clock, .advance, .value(num_ff), .result(lnum));
   thermdiv_log2 u_log_den (.clock, .advance, .value(den_ff), .result(lden));

   logic [DIV_W-1:0] bq_raw;
   side_type         sb;
   thermdiv_div #(.tag_type(side_type)) u_div_tref (
      .clock, .advance, .dividend(sa_ff.bnum), .divisor(DEN_W'(tc_ff)),
      .tag_in(sa_ff), .quotient(bq_raw), .tag_out(sb));

   // Align the log pipe to the divider with a delay line.
   localparam int ALIGN = (DIV_W + 1) - (LOG_FRAC + 1);
   logic signed [LOG_W:0] l_dly [0:ALIGN];
   always_comb l_dly[0] = signed'({1'b0, lnum}) - signed'({1'b0, lden});
   for (genvar k = 0; k < ALIGN; k++) begin : g_al
      always_ff @(posedge clock) if (advance) l_dly[k+1] <= l_dly[k];
   end

   // Stage C: ln = L * ln2 (rounded magnitude), then D = ln + B/Tref.
   logic signed [LOG_W:0] lv;
   logic [LOG_W-1:0]      mag;
   logic [63:0]           lnm_ff;
   logic                  neg_ff;
   logic [DIV_W-1:0]      bq_ff;
   side_type              sc_ff;
   assign lv  = l_dly[ALIGN];
   assign mag = lv[LOG_W] ? LOG_W'(-lv) : LOG_W'(lv);
   always_ff @(posedge clock) begin
      if (advance) begin
         lnm_ff <= (64'(mag) * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
         neg_ff <= lv[LOG_W];
         bq_ff  <= bq_raw;
         sc_ff  <= sb;
      end
   end

   logic signed [DEN_W:0] d_ff;
   side_type              sd_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff  <= (neg_ff ? -signed'((DEN_W+1)'(lnm_ff)) : signed'((DEN_W+1)'(lnm_ff)))
                  + signed'((DEN_W+1)'(bq_ff));
         sd_ff <= sc_ff;
      end
   end

   // Stage D: temperature in centikelvin = B*100*2^20 / D.
   typedef struct packed {
      side_type side;
      logic     dpos;
   } tail_type;
   tail_type         te_in, te;
   logic [DIV_W-1:0] tk;
   assign te_in.side = sd_ff;
   assign te_in.dpos = !d_ff[DEN_W] && (d_ff != '0);
   thermdiv_div #(.tag_type(tail_type)) u_div_temp (
      .clock, .advance, .dividend(sd_ff.bnum),
      .divisor(te_in.dpos ? d_ff[DEN_W-1:0] : DEN_W'(1)),
      .tag_in(te_in), .quotient(tk), .tag_out(te));

   // Stage E: subtract absolute zero, saturate, zero the word on a bad status, register the output word.
   logic signed [DIV_W:0] t;
   assign t = signed'({1'b0, tk}) - (DIV_W+1)'(ABS_ZERO_CENTI);
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[DEPTH-1];
      end
      if (advance) begin
         out_status_ff <= te.side.status;
         if (te.side.status != ST_OK) out_temp_ff <= '0;
         else if (!te.dpos) out_temp_ff <= 16'h7FFF;
         else if (t > 32767) out_temp_ff <= 16'h7FFF;
         else if (t < -32768) out_temp_ff <= 16'h8000;
         else out_temp_ff <= t[15:0];
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = {out_temp_ff, out_status_ff};

endmodule
